FILE: hdl/rvalu_pkg.sv
// ----------------------------------------------------------------------------
// rvalu_pkg
// Operation codes, pipeline payload types and the division step for the
// RV32IM execute-stage ALU.
// ----------------------------------------------------------------------------
package rvalu_pkg;

  localparam int unsigned XLEN      = 32;
  localparam int unsigned REG_W     = 5;
  localparam int unsigned KIND_W    = 5;
  localparam int unsigned DIV_STEPS = XLEN;

  localparam logic [XLEN-1:0] ALL_ONES = {XLEN{1'b1}};
  localparam logic [XLEN-1:0] MIN_NEG  = {1'b1, {(XLEN-1){1'b0}}};

  typedef enum logic [KIND_W-1:0] {
    OP_LUI   = 5'd0,
    OP_AUIPC = 5'd1,
    OP_ADD   = 5'd2,
    OP_SUB   = 5'd3,
    OP_SLL   = 5'd4,
    OP_SLT   = 5'd5,
    OP_SLTU  = 5'd6,
    OP_XOR   = 5'd7,
    OP_SRL   = 5'd8,
    OP_SRA   = 5'd9,
    OP_OR    = 5'd10,
    OP_AND   = 5'd11,
    OP_MUL   = 5'd12,
    OP_MULH  = 5'd13,
    OP_DIV   = 5'd14,
    OP_DIVU  = 5'd15,
    OP_REM   = 5'd16,
    OP_REMU  = 5'd17
  } kind_t;

  // First stage: simple result, raw product, division setup
  typedef struct packed {
    logic [XLEN-1:0]   res;
    logic [REG_W-1:0]  rd;
    logic              is_mul;
    logic              is_mulh;
    logic [2*XLEN-1:0] prod;
    logic [XLEN-1:0]   corr;
    logic              use_div;
    logic              take_rem;
    logic              neg;
    logic [XLEN-1:0]   mag_a;
    logic [XLEN-1:0]   mag_b;
  } front_t;

  // Division stages: one quotient bit per stage
  typedef struct packed {
    logic [XLEN-1:0]  res;
    logic [REG_W-1:0] rd;
    logic             use_div;
    logic             take_rem;
    logic             neg;
    logic [XLEN-1:0]  rem;
    logic [XLEN-1:0]  quo;
    logic [XLEN-1:0]  dvs;
  } div_stage_t;

  // One restoring division step: returns {remainder, quotient/dividend}
  function automatic logic [2*XLEN-1:0] div_step(input logic [XLEN-1:0] rem,
                                                input logic [XLEN-1:0] quo,
                                                input logic [XLEN-1:0] dvs);
    logic [XLEN:0] trial;
    logic [XLEN:0] diff;
    trial = {rem, quo[XLEN-1]};
    diff  = trial - {1'b0, dvs};
    if (!diff[XLEN]) begin
      div_step = {diff[XLEN-1:0], quo[XLEN-2:0], 1'b1};
    end else begin
      div_step = {trial[XLEN-1:0], quo[XLEN-2:0], 1'b0};
    end
  endfunction

endpackage

FILE: hdl/rv32im_integer_alu.sv
// ----------------------------------------------------------------------------
// rv32im_integer_alu
// Execute-stage ALU for RV32IM: base integer ops, mul/mulh and a fully
// pipelined restoring divider.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_ready   | kind, operand_a, operand_b, pc_value, dest_reg
// out     | output    | out_valid / out_ready | result_value, write_reg
//
// Every op takes the same path: one front stage (ALU, 32x32 multiplier),
// 32 divider stages (one quotient bit each; the first also fixes up mulh),
// and an output register, in that order from accept to result.
// One item per cycle is accepted while the pipe advances; the divider stage chain sets the latency.
// The whole pipe advances when the output register is empty or taken.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module rv32im_integer_alu (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [rvalu_pkg::KIND_W-1:0]  kind,
  input  logic [rvalu_pkg::XLEN-1:0]    operand_a,
  input  logic [rvalu_pkg::XLEN-1:0]    operand_b,
  input  logic [rvalu_pkg::XLEN-1:0]    pc_value,
  input  logic [rvalu_pkg::REG_W-1:0]   dest_reg,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [rvalu_pkg::XLEN-1:0]    result_value,
  output logic [rvalu_pkg::REG_W-1:0]   write_reg
);
  import rvalu_pkg::*;

  logic                 advance;
  front_t               front_next;
  front_t               front;
  logic                 front_vld;
  div_stage_t           stage [DIV_STEPS];
  logic [DIV_STEPS-1:0] stage_vld;
  div_stage_t           first_next;
  logic [2*XLEN-1:0]    first_step;
  logic [XLEN-1:0]      final_mag;
  logic [XLEN-1:0]      final_res;

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance;

  // Front stage
  always_comb begin
    logic [4:0]  sh;
    logic        sgn;
    logic        dz;
    logic        ovf;
    logic        is_div;
    sh     = operand_b[4:0];
    front_next         = '0;
    front_next.rd      = dest_reg;
    front_next.prod    = {{XLEN{1'b0}}, operand_a} * {{XLEN{1'b0}}, operand_b};
    front_next.corr    = (operand_a[XLEN-1] ? operand_b : '0) +
                         (operand_b[XLEN-1] ? operand_a : '0);
    sgn    = 1'b0;
    is_div = 1'b0;
    case (kind_t'(kind))
      OP_LUI:   front_next.res = operand_b;
      OP_AUIPC: front_next.res = pc_value + operand_b;
      OP_ADD:   front_next.res = operand_a + operand_b;
      OP_SUB:   front_next.res = operand_a - operand_b;
      OP_SLL:   front_next.res = operand_a << sh;
      OP_SLT:   front_next.res = {31'd0, $signed(operand_a) < $signed(operand_b)};
      OP_SLTU:  front_next.res = {31'd0, operand_a < operand_b};
      OP_XOR:   front_next.res = operand_a ^ operand_b;
      OP_SRL:   front_next.res = operand_a >> sh;
      OP_SRA:   front_next.res = XLEN'($signed(operand_a) >>> sh);
      OP_OR:    front_next.res = operand_a | operand_b;
      OP_AND:   front_next.res = operand_a & operand_b;
      OP_MUL:   front_next.is_mul = 1'b1;
      OP_MULH:  front_next.is_mulh = 1'b1;
      OP_DIV: begin
        is_div = 1'b1;
        sgn    = 1'b1;
      end
      OP_DIVU:  is_div = 1'b1;
      OP_REM: begin
        is_div = 1'b1;
        sgn    = 1'b1;
        front_next.take_rem = 1'b1;
      end
      OP_REMU: begin
        is_div = 1'b1;
        front_next.take_rem = 1'b1;
      end
      default: begin
        front_next.rd = '0;
      end
    endcase
    dz  = (operand_b == '0);
    ovf = sgn && (operand_a == MIN_NEG) && (operand_b == ALL_ONES);
    front_next.mag_a = (sgn && operand_a[XLEN-1]) ? -operand_a : operand_a;
    front_next.mag_b = (sgn && operand_b[XLEN-1]) ? -operand_b : operand_b;
    front_next.neg   = front_next.take_rem ? (sgn && operand_a[XLEN-1])
                                           : (sgn && (operand_a[XLEN-1] ^ operand_b[XLEN-1]));
    front_next.use_div = is_div && !dz && !ovf;
    if (is_div && dz) begin
      front_next.res = front_next.take_rem ? operand_a : ALL_ONES;
    end else if (is_div && ovf) begin
      front_next.res = front_next.take_rem ? '0 : MIN_NEG;
    end
  end

  // First divider stage also finishes the multiply
  always_comb begin
    first_step          = div_step('0, front.mag_a, front.mag_b);
    first_next.rd       = front.rd;
    first_next.use_div  = front.use_div;
    first_next.take_rem = front.take_rem;
    first_next.neg      = front.neg;
    first_next.dvs      = front.mag_b;
    first_next.rem      = first_step[2*XLEN-1:XLEN];
    first_next.quo      = first_step[XLEN-1:0];
    if (front.is_mul) begin
      first_next.res = front.prod[XLEN-1:0];
    end else if (front.is_mulh) begin
      first_next.res = front.prod[2*XLEN-1:XLEN] - front.corr;
    end else begin
      first_next.res = front.res;
    end
  end

  always_comb begin
    final_mag = stage[DIV_STEPS-1].take_rem ? stage[DIV_STEPS-1].rem
                                            : stage[DIV_STEPS-1].quo;
    if (stage[DIV_STEPS-1].use_div) begin
      final_res = stage[DIV_STEPS-1].neg ? -final_mag : final_mag;
    end else begin
      final_res = stage[DIV_STEPS-1].res;
    end
  end

  always_ff @(posedge clk) begin
    logic [2*XLEN-1:0] step;
    div_stage_t        nxt;
    if (advance) begin
      front    <= front_next;
      stage[0] <= first_next;
      for (int k = 1; k < DIV_STEPS; k++) begin
        step     = div_step(stage[k-1].rem, stage[k-1].quo, stage[k-1].dvs);
        nxt      = stage[k-1];
        nxt.rem  = step[2*XLEN-1:XLEN];
        nxt.quo  = step[XLEN-1:0];
        stage[k] <= nxt;
      end
      result_value <= final_res;
      write_reg    <= stage[DIV_STEPS-1].rd;
    end
    if (rst) begin
      front_vld <= 1'b0;
      stage_vld <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      front_vld <= in_valid;
      stage_vld <= {stage_vld[DIV_STEPS-2:0], front_vld};
      out_valid <= stage_vld[DIV_STEPS-1];
    end
  end

endmodule

FILE: hdl/rvalu_checker.sv
// ----------------------------------------------------------------------------
// rvalu_checker
// Port-level checks for the RV32IM execute-stage ALU, bound to the top level.
// ----------------------------------------------------------------------------
module rvalu_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] result_value,
  input logic [4:0]  write_reg
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(write_reg))
    else $error("stalled result changed");

  // Empty output register never blocks input
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // Stalled output freezes the pipe
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  // Reset drops all items
  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result after reset");

endmodule

bind rv32im_integer_alu rvalu_checker u_rvalu_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .result_value (result_value),
  .write_reg    (write_reg)
);

FILE: dv/rv32im_integer_alu_checker.sv
// ----------------------------------------------------------------------------
// rv32im_integer_alu_checker
// Watches the input and output channels of the ALU, computes the expected
// write-back for every accepted item and compares results in order.
// ----------------------------------------------------------------------------
module rv32im_integer_alu_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  logic [rvalu_pkg::KIND_W-1:0]       kind,
  input  logic [rvalu_pkg::XLEN-1:0]         operand_a,
  input  logic [rvalu_pkg::XLEN-1:0]         operand_b,
  input  logic [rvalu_pkg::XLEN-1:0]         pc_value,
  input  logic [rvalu_pkg::REG_W-1:0]        dest_reg,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  logic [rvalu_pkg::XLEN-1:0]         result_value,
  input  logic [rvalu_pkg::REG_W-1:0]        write_reg,
  output int                                 fail_count,
  output int                                 pending_count
);
  import rvalu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [XLEN-1:0]  value;
    logic [REG_W-1:0] rd;
  } writeback_t;

  writeback_t pending_writebacks[$];

  function automatic logic [XLEN-1:0] abs_val(logic [XLEN-1:0] v);
    return v[XLEN-1] ? -v : v;
  endfunction

  function automatic writeback_t compute_writeback(logic [KIND_W-1:0] k,
      logic [XLEN-1:0] a, logic [XLEN-1:0] b, logic [XLEN-1:0] pc,
      logic [REG_W-1:0] rd);
    writeback_t w;
    logic [4:0] sh;
    logic [2*XLEN-1:0] prod;
    logic [XLEN-1:0] q;
    sh = b[4:0];
    w.rd = rd;
    w.value = '0;
    case (k)
      OP_LUI:   w.value = b;
      OP_AUIPC: w.value = pc + b;
      OP_ADD:   w.value = a + b;
      OP_SUB:   w.value = a - b;
      OP_SLL:   w.value = a << sh;
      OP_SLT:   w.value = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      OP_SLTU:  w.value = (a < b) ? 32'd1 : 32'd0;
      OP_XOR:   w.value = a ^ b;
      OP_SRL:   w.value = a >> sh;
      OP_SRA:   w.value = $signed(a) >>> sh;
      OP_OR:    w.value = a | b;
      OP_AND:   w.value = a & b;
      OP_MUL:   w.value = a * b;
      OP_MULH: begin
        prod = $signed({{XLEN{a[XLEN-1]}}, a}) * $signed({{XLEN{b[XLEN-1]}}, b});
        w.value = prod[2*XLEN-1:XLEN];
      end
      OP_DIV: begin
        if (b == 0) w.value = ALL_ONES;
        else if (a == MIN_NEG && b == ALL_ONES) w.value = MIN_NEG;
        else begin
          q = abs_val(a) / abs_val(b);
          w.value = (a[XLEN-1] ^ b[XLEN-1]) ? -q : q;
        end
      end
      OP_DIVU:  w.value = (b == 0) ? ALL_ONES : a / b;
      OP_REM: begin
        if (b == 0) w.value = a;
        else if (a == MIN_NEG && b == ALL_ONES) w.value = '0;
        else begin
          q = abs_val(a) % abs_val(b);
          w.value = a[XLEN-1] ? -q : q;
        end
      end
      OP_REMU:  w.value = (b == 0) ? a : a % b;
      default: begin
        w.value = '0;
        w.rd = '0;
      end
    endcase
    return w;
  endfunction

  assign pending_count = pending_writebacks.size();

  always @(posedge clk) begin
    writeback_t want;
    int         errs;
    errs = 0;
    if (!rst) begin
      if (in_valid && in_ready)
        pending_writebacks.push_back(compute_writeback(kind, operand_a, operand_b,
                                                       pc_value, dest_reg));
      if (out_valid && out_ready) begin
        if (pending_writebacks.size() == 0) begin
          $error("unexpected result: result_value %h write_reg %0d",
                 result_value, write_reg);
          errs++;
        end else begin
          want = pending_writebacks.pop_front();
          if (result_value !== want.value) begin
            $error("result_value: expected %h, got %h", want.value, result_value);
            errs++;
          end
          if (write_reg !== want.rd) begin
            $error("write_reg: expected %0d, got %0d", want.rd, write_reg);
            errs++;
          end
        end
      end
    end
    if (errs != 0) fail_count <= fail_count + errs;
  end
endmodule

FILE: dv/rv32im_integer_alu_test.sv
// ----------------------------------------------------------------------------
// rv32im_integer_alu_test
// Drives directed corner cases and random instructions into the ALU with
// random gaps and output stalls; the checker compares every write-back.
// ----------------------------------------------------------------------------
module rv32im_integer_alu_test;
  import rvalu_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIPE_CYCLES = 34;
  localparam int RANDOM_ITEMS = 1500;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [KIND_W-1:0] kind;
  logic [XLEN-1:0]   operand_a;
  logic [XLEN-1:0]   operand_b;
  logic [XLEN-1:0]   pc_value;
  logic [REG_W-1:0]  dest_reg;
  logic              out_valid;
  logic              out_ready;
  logic [XLEN-1:0]   result_value;
  logic [REG_W-1:0]  write_reg;
  int                fail_count;
  int                pending_count;
  logic              long_stall_req;

  rv32im_integer_alu dut (.*);

  rv32im_integer_alu_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  function automatic logic [XLEN-1:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return ALL_ONES;
      2: return MIN_NEG;
      3: return MIN_NEG - 1;
      4: return $urandom_range(0, 15);
      5: return -$urandom_range(1, 15);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(logic [KIND_W-1:0] k, logic [XLEN-1:0] a,
                           logic [XLEN-1:0] b, logic [XLEN-1:0] pc,
                           logic [REG_W-1:0] rd, bit no_gap);
    int gap;
    gap = no_gap ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    operand_a <= a;
    operand_b <= b;
    pc_value  <= pc;
    dest_reg  <= rd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // output side: random stalls, plus one long hold on request
  initial begin
    int n;
    bit long_done;
    long_done = 1'b0;
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_stall_req && !long_done) begin
        out_ready <= 1'b0;
        repeat (120) @(posedge clk);
        out_ready <= 1'b1;
        long_done = 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        n = gap_len();
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int i;
    logic [KIND_W-1:0] k;
    rst            = 1'b1;
    long_stall_req = 1'b0;
    in_valid       = 1'b0;
    kind           = '0;
    operand_a      = '0;
    operand_b      = '0;
    pc_value       = '0;
    dest_reg       = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every op at corner operands, divide by zero, overflow, large shift, undefined kinds
    for (i = 0; i <= OP_REMU; i++)
      send_item(KIND_W'(i), MIN_NEG, ALL_ONES, ALL_ONES, 5'd31, 1'b0);
    send_item(OP_DIV,  32'd7, '0, '0, 5'd1, 1'b0);
    send_item(OP_DIVU, 32'd7, '0, '0, 5'd2, 1'b0);
    send_item(OP_REM,  MIN_NEG, '0, '0, 5'd3, 1'b0);
    send_item(OP_REMU, ALL_ONES, '0, '0, 5'd4, 1'b0);
    send_item(OP_SLL,  32'h1, 32'hFFFF_FFE1, '0, 5'd5, 1'b0);
    send_item(5'd18,   ALL_ONES, ALL_ONES, ALL_ONES, 5'd6, 1'b0);
    send_item(5'd31,   '0, '0, '0, 5'd7, 1'b0);
    drain();

    // long output hold while the input keeps offering items
    long_stall_req = 1'b1;
    for (i = 0; i < 60; i++)
      send_item(KIND_W'($urandom_range(0, OP_REMU)), $urandom, $urandom, $urandom,
                REG_W'($urandom), 1'b1);
    drain();

    for (i = 0; i < RANDOM_ITEMS; i++) begin
      k = KIND_W'(($urandom_range(0, 19) == 0) ? $urandom_range(18, 31)
                                               : $urandom_range(0, OP_REMU));
      send_item(k, pick_operand(), pick_operand(), $urandom, REG_W'($urandom),
                $urandom_range(0, 2) == 0);
      if (i == RANDOM_ITEMS / 2) drain();
    end
    drain();
    repeat (PIPE_CYCLES + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

FILE: files.f
hdl/rvalu_pkg.sv
hdl/rv32im_integer_alu.sv
hdl/rvalu_checker.sv
dv/rv32im_integer_alu_checker.sv
dv/rv32im_integer_alu_test.sv
